### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and codes for the per-source statistics counter table:
// request codes, the per-source record layout and the global totals.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Request codes carried in the input tuser field
    typedef enum logic [3:0] {
        REQ_RX        = 4'd0,
        REQ_MALFORMED = 4'd1,
        REQ_GAP       = 4'd2,
        REQ_REORDER   = 4'd3,
        REQ_DUPLICATE = 4'd4,
        REQ_CRC_FAIL  = 4'd5,
        REQ_QUERY_SRC = 4'd6,
        REQ_QUERY_GLB = 4'd7,
        REQ_CLEAR     = 4'd8
    } req_t;

    // Health codes
    typedef enum logic [1:0] {
        HEALTH_OK       = 2'd0,
        HEALTH_DEGRADED = 2'd1,
        HEALTH_ERROR    = 2'd2
    } health_t;

    localparam int unsigned CNT_W  = 64;
    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned TS_W   = 64;
    localparam int unsigned ID_W   = 16;
    localparam int unsigned GAP_W  = 32;
    localparam int unsigned REQ_W  = 4;

    // One per-source record, stored as one memory word
    typedef struct packed {
        logic [CNT_W-1:0] rx;
        logic [CNT_W-1:0] malformed;
        logic [CNT_W-1:0] gap;
        logic [CNT_W-1:0] reorder;
        logic [CNT_W-1:0] duplicate;
        logic [SEQ_W-1:0] recent_seq;
        logic [TS_W-1:0]  last_time;
    } rec_t;

    // Global totals
    typedef struct packed {
        logic [CNT_W-1:0] rx;
        logic [CNT_W-1:0] malformed;
        logic [CNT_W-1:0] gap;
        logic [CNT_W-1:0] reorder;
        logic [CNT_W-1:0] duplicate;
        logic [CNT_W-1:0] crc;
    } glob_t;

    // Health from the global totals
    function automatic health_t health_of(input glob_t g);
        health_t h;
        h = HEALTH_OK;
        if ((g.malformed != '0) || (g.crc != '0))
        begin
            h = HEALTH_ERROR;
        end
        else if ((g.gap != '0) || (g.reorder != '0))
        begin
            h = HEALTH_DEGRADED;
        end
        return h;
    endfunction

endpackage

### src/psc_rec_mem.sv
// ----------------------------------------------------------------------------
// psc_rec_mem
// Per-source record store: one write port, one read port, registered read
// data. Entries are zeroed on allocation by the control logic, not here.
// ----------------------------------------------------------------------------
module psc_rec_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output psc_pkg::rec_t         rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  psc_pkg::rec_t         wr_data
);

    psc_pkg::rec_t mem [DEPTH];
    psc_pkg::rec_t rd_data_reg;

    // Write back, and read into a registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/psc_tag_cam.sv
// ----------------------------------------------------------------------------
// psc_tag_cam
// Source tag store with a parallel match. Entries below the fill count are
// valid; tags are written when an entry is allocated.
// ----------------------------------------------------------------------------
module psc_tag_cam #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IW    = 6,
    parameter int unsigned CW    = 7
) (
    input  logic                         clk,
    input  logic [psc_pkg::ID_W-1:0]     lookup_id,
    input  logic [CW-1:0]                used_cnt,
    input  logic                         wr_en,
    input  logic [IW-1:0]                wr_idx,
    input  logic [psc_pkg::ID_W-1:0]     wr_tag,
    output logic                         hit,
    output logic [IW-1:0]                hit_idx
);

    logic [psc_pkg::ID_W-1:0] tag_reg [DEPTH];
    logic [DEPTH-1:0]         match;

    // Store the tag of a newly allocated entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_reg[wr_idx] <= wr_tag;
        end
    end

    // Compare every valid entry against the lookup id
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (CW'(i) < used_cnt) && (tag_reg[i] == lookup_id);
        end
    end

    // Encode the match; tags of valid entries are unique
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    assign hit = |match;

endmodule

### src/per_source_stats_counter_table.sv
// ----------------------------------------------------------------------------
// per_source_stats_counter_table
// Packet-stream statistics engine: global totals plus a bounded table of
// per-source records, with queries, clear and health reporting.
//
//  Channel   Dir  tdata                                tuser
//  s_axis    in   source_id, sequence_number,          req_type
//                 timestamp_ns, gap_length (144 b)
//  m_axis    out  received_count .. crc_fail_count     source_known, health,
//                 (480 b)                              entry_dropped
//
// In each transaction the tag match runs on the incoming source id and
// issues the record read at the accept edge; the write-back edge, once the
// output register can take the result, writes the modified record back and
// loads the output register, as the record memory has a registered read.
// Reset clears the totals and the fill count; the record memory needs no
// clearing since an allocated entry is built from zeros.
// A new transaction is taken while a finished result still waits; the block
// holds in write-back only while the output register is full and not taken.
// ----------------------------------------------------------------------------
module per_source_stats_counter_table #(
    parameter int unsigned MAX_SOURCES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // [15:0] source_id, [47:16] sequence_number, [111:48] timestamp_ns,
    // [143:112] gap_length
    input  logic [143:0]   s_tdata,
    // [3:0] req_type
    input  logic [3:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    // [63:0] received_count, [95:64] last_sequence, [159:96] last_timestamp,
    // [223:160] malformed_count, [287:224] gap_count, [351:288] reorder_count,
    // [415:352] duplicate_count, [479:416] crc_fail_count
    output logic [479:0]   m_tdata,
    // [0] source_known, [2:1] health, [3] entry_dropped
    output logic [3:0]     m_tuser
);

    localparam int unsigned IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int unsigned CW = $clog2(MAX_SOURCES + 1);

    // Input fields
    logic [psc_pkg::ID_W-1:0]  in_id;
    logic [psc_pkg::SEQ_W-1:0] in_seq;
    logic [psc_pkg::TS_W-1:0]  in_ts;
    logic [psc_pkg::GAP_W-1:0] in_gap;

    assign in_id  = s_tdata[15:0];
    assign in_seq = s_tdata[47:16];
    assign in_ts  = s_tdata[111:48];
    assign in_gap = s_tdata[143:112];

    // Control and transaction registers
    logic                       busy_reg;
    logic [psc_pkg::REQ_W-1:0]  req_reg;
    logic [psc_pkg::ID_W-1:0]   id_reg;
    logic [psc_pkg::SEQ_W-1:0]  seq_reg;
    logic [psc_pkg::TS_W-1:0]   ts_reg;
    logic [psc_pkg::GAP_W-1:0]  gap_reg;
    logic                       hit_reg;
    logic                       full_reg;
    logic [IW-1:0]              idx_reg;
    logic [CW-1:0]              used_reg;
    logic [CW-1:0]              used_next;
    psc_pkg::glob_t             glob_reg;
    psc_pkg::glob_t             glob_next;

    // Output register
    logic                       m_tvalid_reg;
    logic [479:0]               m_tdata_reg;
    logic [479:0]               m_tdata_next;
    logic [3:0]                 m_tuser_reg;
    logic [3:0]                 m_tuser_next;

    logic                       accept;
    logic                       done;
    logic                       cam_hit;
    logic [IW-1:0]              cam_idx;
    logic                       is_event;
    logic                       present;
    logic                       mem_wr;
    logic                       alloc;
    psc_pkg::rec_t              rd_rec;
    psc_pkg::rec_t              base_rec;
    psc_pkg::rec_t              new_rec;
    psc_pkg::rec_t              out_rec;
    logic                       out_known;
    logic                       out_drop;
    logic [psc_pkg::CNT_W-1:0]  out_crc;
    psc_pkg::health_t           out_health;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign done     = busy_reg && (!m_tvalid_reg || m_tready);

    // Tag lookup on the incoming source id
    psc_tag_cam #(
        .DEPTH (MAX_SOURCES),
        .IW    (IW),
        .CW    (CW)
    ) u_tag_cam (
        .clk       (clk),
        .lookup_id (in_id),
        .used_cnt  (used_reg),
        .wr_en     (alloc),
        .wr_idx    (idx_reg),
        .wr_tag    (id_reg),
        .hit       (cam_hit),
        .hit_idx   (cam_idx)
    );

    // Record memory
    psc_rec_mem #(
        .DEPTH (MAX_SOURCES),
        .AW    (IW)
    ) u_rec_mem (
        .clk     (clk),
        .rd_en   (accept && cam_hit),
        .rd_addr (cam_idx),
        .rd_data (rd_rec),
        .wr_en   (mem_wr),
        .wr_addr (idx_reg),
        .wr_data (new_rec)
    );

    // Capture the transaction and the lookup result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_tuser;
            id_reg   <= in_id;
            seq_reg  <= in_seq;
            ts_reg   <= in_ts;
            gap_reg  <= in_gap;
            hit_reg  <= cam_hit;
            full_reg <= (used_reg == CW'(MAX_SOURCES));
            idx_reg  <= cam_hit ? cam_idx : used_reg[IW-1:0];
        end
    end

    // Modify the record; a new entry starts from zeros
    assign is_event = (req_reg <= psc_pkg::REQ_CRC_FAIL);
    assign present  = hit_reg || !full_reg;
    assign base_rec = hit_reg ? rd_rec : '0;

    always_comb
    begin
        new_rec = base_rec;
        unique case (req_reg)
            psc_pkg::REQ_RX:
            begin
                new_rec.rx         = base_rec.rx + 64'd1;
                new_rec.recent_seq = seq_reg;
                new_rec.last_time  = ts_reg;
            end
            psc_pkg::REQ_MALFORMED,
            psc_pkg::REQ_CRC_FAIL:
            begin
                new_rec.malformed = base_rec.malformed + 64'd1;
            end
            psc_pkg::REQ_GAP:
            begin
                new_rec.gap = base_rec.gap + {32'd0, gap_reg};
            end
            psc_pkg::REQ_REORDER:
            begin
                new_rec.reorder = base_rec.reorder + 64'd1;
            end
            psc_pkg::REQ_DUPLICATE:
            begin
                new_rec.duplicate = base_rec.duplicate + 64'd1;
            end
            default:
            begin
                new_rec = base_rec;
            end
        endcase
    end

    assign mem_wr = done && is_event && present;
    assign alloc  = mem_wr && !hit_reg;

    // Update global totals and the fill count
    always_comb
    begin
        glob_next = glob_reg;
        used_next = used_reg;
        unique case (req_reg)
            psc_pkg::REQ_RX:        glob_next.rx        = glob_reg.rx + 64'd1;
            psc_pkg::REQ_MALFORMED: glob_next.malformed = glob_reg.malformed + 64'd1;
            psc_pkg::REQ_GAP:       glob_next.gap       = glob_reg.gap + {32'd0, gap_reg};
            psc_pkg::REQ_REORDER:   glob_next.reorder   = glob_reg.reorder + 64'd1;
            psc_pkg::REQ_DUPLICATE: glob_next.duplicate = glob_reg.duplicate + 64'd1;
            psc_pkg::REQ_CRC_FAIL:  glob_next.crc       = glob_reg.crc + 64'd1;
            psc_pkg::REQ_CLEAR:
            begin
                glob_next = '0;
                used_next = '0;
            end
            default:
            begin
                glob_next = glob_reg;
            end
        endcase
        if (alloc)
        begin
            used_next = used_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glob_reg <= '0;
            used_reg <= '0;
        end
        else if (done)
        begin
            glob_reg <= glob_next;
            used_reg <= used_next;
        end
    end

    // Build the result
    always_comb
    begin
        out_rec   = '0;
        out_known = 1'b0;
        out_drop  = 1'b0;
        out_crc   = '0;
        if (is_event)
        begin
            if (present)
            begin
                out_known = 1'b1;
                out_rec   = new_rec;
            end
            else
            begin
                out_drop = 1'b1;
            end
        end
        else if (req_reg == psc_pkg::REQ_QUERY_SRC)
        begin
            if (hit_reg)
            begin
                out_known = 1'b1;
                out_rec   = rd_rec;
            end
        end
        else if (req_reg == psc_pkg::REQ_QUERY_GLB)
        begin
            out_rec.rx        = glob_reg.rx;
            out_rec.malformed = glob_reg.malformed;
            out_rec.gap       = glob_reg.gap;
            out_rec.reorder   = glob_reg.reorder;
            out_rec.duplicate = glob_reg.duplicate;
            out_crc           = glob_reg.crc;
        end
        out_health   = psc_pkg::health_of(glob_next);
        m_tdata_next = {out_crc, out_rec.duplicate, out_rec.reorder, out_rec.gap,
                        out_rec.malformed, out_rec.last_time, out_rec.recent_seq,
                        out_rec.rx};
        m_tuser_next = {out_drop, out_health, out_known};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_SOURCES))
        else $error("fill count above table size");

    // An accepted transaction occupies the engine in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted transaction not in progress");

    // Allocation grows the fill count by one
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> (used_reg == $past(used_reg) + CW'(1)))
        else $error("allocation did not advance fill count");

    // A dropped source is never reported as known
    a_drop_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[3] && m_tuser[0]))
        else $error("dropped source reported as known");

    // Health never takes the unused code
    a_health_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2:1] != 2'b11))
        else $error("invalid health code");

endmodule
